>>> hw/rtl/rpac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpac_pkg
// Shared types and constants for the point rotation block: request and
// response payloads, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rpac_pkg;

   localparam int unsigned CORDIC_STAGES_DEFAULT = 24;
   localparam int unsigned ATAN_ENTRIES = 32;

   // Angles in 1/128 degree.
   localparam logic [16:0] ANGLE_OFFSET = 17'd115200;  // half turn plus two full turns
   localparam logic [16:0] FULL_TURN    = 17'd46080;
   localparam logic [15:0] HALF_TURN    = 16'd23040;
   localparam logic [15:0] QUARTER_TURN = 16'd11520;
   localparam logic [15:0] THREE_QUARTER_TURN = 16'd34560;

   // theta = round(mag * 2^22 / 45) = mag * 93206 + floor((34 * mag + 22) / 45).
   localparam logic [16:0] THETA_WHOLE = 17'd93206;
   localparam logic [5:0]  THETA_REM   = 6'd34;
   localparam logic [4:0]  THETA_BIAS  = 5'd22;
   localparam logic [19:0] RECIP_45    = 20'd745655;  // ceil(2^25 / 45)
   localparam int unsigned RECIP_SHIFT = 25;

   // CORDIC start value: inverse of the limit gain in Q30.
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

   localparam logic [31:0] ATAN_BAM [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic        [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rotated_x;
      logic signed [31:0] rotated_y;
      logic               saturated;
   } rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/rotate_point_about_center.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_point_about_center
// Rotates a point about a center by (180 - heading) degrees using a
// gain-compensated CORDIC, with rounding and saturation of the result.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle and never stalls: busy is always
// low, so a request is taken whenever start is high. Each response is shown
// for one cycle with rsp_strobe high, in request order. Requests pass through
// four stages of angle conversion, the CORDIC with one registered stage per
// iteration (CORDIC_STAGES, capped at ATAN_ENTRIES), and four stages of
// multiply, round and saturate.
module rotate_point_about_center #(
   parameter int unsigned CORDIC_STAGES = rpac_pkg::CORDIC_STAGES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rpac_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output rpac_pkg::rsp_type     rsp_data
);
   import rpac_pkg::*;

   localparam int unsigned NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   localparam int unsigned CW = 34;  // CORDIC datapath width
   localparam int unsigned PW = 65;  // product width
   localparam int unsigned SW = 66;  // sum of products width

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               flip;
   } pay_type;

   // ---------------- Stage 1: angle reduction and offsets ----------------
   logic          s1_vld_ff;
   logic [15:0]   s1_a_ff, s1_a_in;
   pay_type       s1_pay_ff, s1_pay_in;
   logic [16:0]   s1_v, s1_v1;

   assign busy = 1'b0;

   always_comb begin
      s1_v  = ANGLE_OFFSET - {1'b0, req_data.heading};
      s1_v1 = s1_v - FULL_TURN;
      s1_a_in = (s1_v1 >= FULL_TURN) ? 16'(s1_v1 - FULL_TURN) : s1_v1[15:0];
      s1_pay_in.dx   = 33'(req_data.point_x) - 33'(req_data.center_x);
      s1_pay_in.dy   = 33'(req_data.point_y) - 33'(req_data.center_y);
      s1_pay_in.cx   = req_data.center_x;
      s1_pay_in.cy   = req_data.center_y;
      s1_pay_in.flip = 1'b0;
   end

   // ---------------- Stage 2: fold into [-90, 90] degrees ----------------
   logic          s2_vld_ff;
   logic [13:0]   s2_mag_ff, s2_mag_in;
   logic          s2_neg_ff, s2_neg_in;
   pay_type       s2_pay_ff, s2_pay_in;

   always_comb begin
      s2_pay_in = s1_pay_ff;
      priority if (s1_a_ff > QUARTER_TURN && s1_a_ff < THREE_QUARTER_TURN) begin
         // Middle half: shift by a half turn and negate cosine and sine later.
         s2_pay_in.flip = 1'b1;
         s2_neg_in = (s1_a_ff < HALF_TURN);
         s2_mag_in = s2_neg_in ? 14'(HALF_TURN - s1_a_ff) : 14'(s1_a_ff - HALF_TURN);
      end else if (s1_a_ff >= THREE_QUARTER_TURN) begin
         s2_neg_in = 1'b1;
         s2_mag_in = 14'(FULL_TURN - {1'b0, s1_a_ff});
      end else begin
         s2_neg_in = 1'b0;
         s2_mag_in = s1_a_ff[13:0];
      end
   end

   // ---------------- Stage 3: scale products for angle conversion ----------------
   logic          s3_vld_ff;
   logic [30:0]   s3_base_ff, s3_base_in;
   logic [38:0]   s3_prod_ff, s3_prod_in;
   logic          s3_neg_ff;
   pay_type       s3_pay_ff;
   logic [18:0]   s3_num;

   always_comb begin
      s3_num     = 19'(THETA_REM) * 19'(s2_mag_ff) + 19'(THETA_BIAS);
      s3_base_in = 31'(THETA_WHOLE) * 31'(s2_mag_ff);
      s3_prod_in = 39'(s3_num) * 39'(RECIP_45);
   end

   // ---------------- Stage 4: signed binary angle ----------------
   logic [30:0]   s4_mag;
   logic signed [CW-1:0] s4_theta_in;

   always_comb begin
      s4_mag = s3_base_ff + 31'(s3_prod_ff[38:RECIP_SHIFT]);
      s4_theta_in = s3_neg_ff ? -$signed(CW'(s4_mag)) : $signed(CW'(s4_mag));
   end

   // ---------------- CORDIC stages ----------------
   logic                 cv_vld_ff [NS+1];
   logic signed [CW-1:0] cx_ff [NS+1];
   logic signed [CW-1:0] cy_ff [NS+1];
   logic signed [CW-1:0] cz_ff [NS+1];
   pay_type              cp_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         cv_vld_ff[0] <= 1'b0;
      end else begin
         s1_vld_ff    <= start;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         cv_vld_ff[0] <= s3_vld_ff;
      end
      s1_a_ff    <= s1_a_in;
      s1_pay_ff  <= s1_pay_in;
      s2_mag_ff  <= s2_mag_in;
      s2_neg_ff  <= s2_neg_in;
      s2_pay_ff  <= s2_pay_in;
      s3_base_ff <= s3_base_in;
      s3_prod_ff <= s3_prod_in;
      s3_neg_ff  <= s2_neg_ff;
      s3_pay_ff  <= s2_pay_ff;
      cx_ff[0]   <= $signed(CW'(CORDIC_GAIN_Q30));
      cy_ff[0]   <= '0;
      cz_ff[0]   <= s4_theta_in;
      cp_ff[0]   <= s3_pay_ff;
   end

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      logic signed [CW-1:0] xs, ys, x_in, y_in, z_in, at;

      always_comb begin
         xs = cx_ff[i] >>> i;
         ys = cy_ff[i] >>> i;
         at = $signed(CW'(ATAN_BAM[i]));
         if (!cz_ff[i][CW-1]) begin
            x_in = cx_ff[i] - ys;
            y_in = cy_ff[i] + xs;
            z_in = cz_ff[i] - at;
         end else begin
            x_in = cx_ff[i] + ys;
            y_in = cy_ff[i] - xs;
            z_in = cz_ff[i] + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_vld_ff[i+1] <= 1'b0;
         end else begin
            cv_vld_ff[i+1] <= cv_vld_ff[i];
         end
         cx_ff[i+1] <= x_in;
         cy_ff[i+1] <= y_in;
         cz_ff[i+1] <= z_in;
         cp_ff[i+1] <= cp_ff[i];
      end
   end

   // ---------------- Stage 5: quadrant correction ----------------
   logic                 s5_vld_ff;
   logic signed [31:0]   s5_c_ff, s5_c_in, s5_s_ff, s5_s_in;
   pay_type              s5_pay_ff;
   logic signed [CW-1:0] s5_cn, s5_sn;

   always_comb begin
      s5_cn   = cp_ff[NS].flip ? -cx_ff[NS] : cx_ff[NS];
      s5_sn   = cp_ff[NS].flip ? -cy_ff[NS] : cy_ff[NS];
      s5_c_in = s5_cn[31:0];
      s5_s_in = s5_sn[31:0];
   end

   // ---------------- Stage 6: products ----------------
   logic               s6_vld_ff;
   logic signed [PW-1:0] s6_xc_ff, s6_ys_ff, s6_xs_ff, s6_yc_ff;
   logic signed [PW-1:0] s6_xc_in, s6_ys_in, s6_xs_in, s6_yc_in;
   logic signed [31:0] s6_cx_ff, s6_cy_ff;

   always_comb begin
      s6_xc_in = PW'(s5_pay_ff.dx) * PW'(s5_c_ff);
      s6_ys_in = PW'(s5_pay_ff.dy) * PW'(s5_s_ff);
      s6_xs_in = PW'(s5_pay_ff.dx) * PW'(s5_s_ff);
      s6_yc_in = PW'(s5_pay_ff.dy) * PW'(s5_c_ff);
   end

   // ---------------- Stage 7: sum and round ----------------
   logic               s7_vld_ff;
   logic signed [35:0] s7_rx_ff, s7_ry_ff;
   logic signed [31:0] s7_cx_ff, s7_cy_ff;
   logic signed [SW-1:0] s7_sx, s7_sy;
   localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'd1 << 29);

   always_comb begin
      s7_sx = SW'(s6_xc_ff) - SW'(s6_ys_ff) + ROUND_HALF;
      s7_sy = SW'(s6_xs_ff) + SW'(s6_yc_ff) + ROUND_HALF;
   end

   // ---------------- Stage 8: add center and saturate ----------------
   logic               rsp_strobe_ff;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic signed [36:0] s8_tx, s8_ty;
   logic               s8_sat_x, s8_sat_y;

   always_comb begin
      s8_tx = 37'(s7_cx_ff) + 37'(s7_rx_ff);
      s8_ty = 37'(s7_cy_ff) + 37'(s7_ry_ff);
      // Overflow when the bits above the 32-bit sign do not all match it.
      s8_sat_x = !((&s8_tx[36:31]) || !(|s8_tx[36:31]));
      s8_sat_y = !((&s8_ty[36:31]) || !(|s8_ty[36:31]));
      rsp_data_in.rotated_x = s8_sat_x ? {s8_tx[36], {31{!s8_tx[36]}}} : s8_tx[31:0];
      rsp_data_in.rotated_y = s8_sat_y ? {s8_ty[36], {31{!s8_ty[36]}}} : s8_ty[31:0];
      rsp_data_in.saturated = s8_sat_x | s8_sat_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff     <= 1'b0;
         s6_vld_ff     <= 1'b0;
         s7_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s5_vld_ff     <= cv_vld_ff[NS];
         s6_vld_ff     <= s5_vld_ff;
         s7_vld_ff     <= s6_vld_ff;
         rsp_strobe_ff <= s7_vld_ff;
      end
      s5_c_ff     <= s5_c_in;
      s5_s_ff     <= s5_s_in;
      s5_pay_ff   <= cp_ff[NS];
      s6_xc_ff    <= s6_xc_in;
      s6_ys_ff    <= s6_ys_in;
      s6_xs_ff    <= s6_xs_in;
      s6_yc_ff    <= s6_yc_in;
      s6_cx_ff    <= s5_pay_ff.cx;
      s6_cy_ff    <= s5_pay_ff.cy;
      s7_rx_ff    <= s7_sx[SW-1:30];
      s7_ry_ff    <= s7_sy[SW-1:30];
      s7_cx_ff    <= s6_cx_ff;
      s7_cy_ff    <= s6_cy_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

>>> sim/rotate_point_about_center_tb.sv
// ----------------------------------------------------------------------------
// rotate_point_about_center_tb
// Drives corner points, centers and headings into the rotation block and
// compares each response with a given value or an independent fixed-point
// CORDIC predictor. A short table of corner cases runs first, then a long
// random run with idle bursts and a full drain in the middle and at the end.
// ----------------------------------------------------------------------------
module rotate_point_about_center_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpac_pkg::*;

   localparam int unsigned STAGES = 24;
   localparam int unsigned LATENCY = STAGES + 8;
   localparam int unsigned CORDIC_ITERS = (STAGES > 32) ? 32 : STAGES;
   localparam int unsigned RANDOM_REQUESTS = 450;
   localparam int unsigned CALM_TAIL = 60;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

   // Angles in 1/128 degree.
   localparam longint ANGLE_BASE = 115200;
   localparam longint TURN = 46080;
   localparam longint HALF = 23040;
   localparam longint QUARTER = 11520;
   localparam longint INV_GAIN_Q30 = 652032874;
   localparam longint ROUND_HALF = longint'(1) << 29;

   localparam longint ARCTAN[32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct {
      req_type stim;
      bit      known;
      rsp_type want;
   } corner_case_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type         rotations_due[$];
   corner_case_type corner_cases[$];
   int unsigned failures = 0;
   int unsigned quiet_cycles = 0;

   rotate_point_about_center #(
      .CORDIC_STAGES(STAGES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] clip_coord(input longint v, inout logic clipped);
      if (v > longint'(COORD_MAX)) begin
         clipped = 1'b1;
         return COORD_MAX;
      end
      if (v < longint'(COORD_MIN)) begin
         clipped = 1'b1;
         return COORD_MIN;
      end
      return v[31:0];
   endfunction

   function automatic rsp_type rotated_point(input req_type r);
      longint px, py, cx, cy, ang, mag, theta;
      longint cosv, sinv, z, xs, ys, dx, dy;
      bit flip;
      rsp_type res;
      px = longint'($signed(r.point_x));
      py = longint'($signed(r.point_y));
      cx = longint'($signed(r.center_x));
      cy = longint'($signed(r.center_y));
      ang = (ANGLE_BASE - longint'(r.heading)) % TURN;
      flip = 1'b0;
      // Fold into +/- a quarter turn; the middle half is handled by negation.
      if (ang > QUARTER && ang < TURN - QUARTER) begin
         ang = ang - HALF;
         flip = 1'b1;
      end else if (ang >= TURN - QUARTER) begin
         ang = ang - TURN;
      end
      mag = (ang < 0) ? -ang : ang;
      theta = (mag * 4194304 + 22) / 45;
      if (ang < 0) theta = -theta;
      cosv = INV_GAIN_Q30;
      sinv = 0;
      z = theta;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = cosv >>> i;
         ys = sinv >>> i;
         if (z >= 0) begin
            cosv = cosv - ys;
            sinv = sinv + xs;
            z = z - ARCTAN[i];
         end else begin
            cosv = cosv + ys;
            sinv = sinv - xs;
            z = z + ARCTAN[i];
         end
      end
      if (flip) begin
         cosv = -cosv;
         sinv = -sinv;
      end
      dx = px - cx;
      dy = py - cy;
      res.saturated = 1'b0;
      res.rotated_x = clip_coord(cx + ((dx * cosv - dy * sinv + ROUND_HALF) >>> 30),
                                 res.saturated);
      res.rotated_y = clip_coord(cy + ((dx * sinv + dy * cosv + ROUND_HALF) >>> 30),
                                 res.saturated);
      return res;
   endfunction

   task automatic add_case(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] cx, input logic signed [31:0] cy,
                           input logic [15:0] hdg, input bit known,
                           input logic signed [31:0] ex, input logic signed [31:0] ey,
                           input logic ef);
      corner_case_type row;
      row.stim = '{point_x: px, point_y: py, center_x: cx, center_y: cy, heading: hdg};
      row.known = known;
      row.want = '{rotated_x: ex, rotated_y: ey, saturated: ef};
      corner_cases.push_back(row);
   endtask

   function automatic logic signed [31:0] edge_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return 32'sd0;
         3: return -32'sd1;
         4: return 32'sd1;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      logic signed [31:0] cx, cy;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         // Typical use: a rectangle corner near a center of moderate size.
         cx = $signed($urandom) >>> 9;
         cy = $signed($urandom) >>> 9;
         r.center_x = cx;
         r.center_y = cy;
         r.point_x = cx + ($signed($urandom) >>> 14);
         r.point_y = cy + ($signed($urandom) >>> 14);
      end else if (pick <= 7) begin
         r.point_x = $urandom;
         r.point_y = $urandom;
         r.center_x = $urandom;
         r.center_y = $urandom;
      end else if (pick == 8) begin
         r.point_x = edge_coord();
         r.point_y = edge_coord();
         r.center_x = edge_coord();
         r.center_y = edge_coord();
      end else begin
         // Center close to a limit with a large offset, so clipping is likely.
         r.center_x = ($urandom_range(0, 1) != 0) ? COORD_MAX - $urandom_range(0, 4095)
                                                  : COORD_MIN + $urandom_range(0, 4095);
         r.center_y = ($urandom_range(0, 1) != 0) ? COORD_MAX - $urandom_range(0, 4095)
                                                  : COORD_MIN + $urandom_range(0, 4095);
         r.point_x = $urandom;
         r.point_y = $urandom;
      end
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
         r.heading = $urandom_range(0, 46079);
      end else if (pick < 19) begin
         r.heading = $urandom_range(46080, 65535);
      end else begin
         case ($urandom_range(0, 5))
            0: r.heading = 16'd0;
            1: r.heading = 16'd11520;
            2: r.heading = 16'd23040;
            3: r.heading = 16'd34560;
            4: r.heading = 16'd46079;
            default: r.heading = 16'd46080;
         endcase
      end
      return r;
   endfunction

   task automatic issue(input req_type r, input bit known, input rsp_type want);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      rotations_due.push_back(known ? want : rotated_point(r));
   endtask

   task automatic maybe_idle(input bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Response checker and watchdog; outputs are sampled before the edge updates them.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rotations_due.size() == 0) begin
            $error("rsp: response with no request outstanding");
            failures++;
         end else begin
            want = rotations_due.pop_front();
            if (rsp_data.rotated_x !== want.rotated_x) begin
               $error("rotated_x: expected %0d, got %0d", want.rotated_x, rsp_data.rotated_x);
               failures++;
            end
            if (rsp_data.rotated_y !== want.rotated_y) begin
               $error("rotated_y: expected %0d, got %0d", want.rotated_y, rsp_data.rotated_y);
               failures++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, rsp_data.saturated);
               failures++;
            end
         end
      end
      if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned k;
      bit idling;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;

      // Point on the center stays put; opposite extremes under a half turn clip.
      add_case(0, 0, 0, 0, 16'd0, 1, 0, 0, 1'b0);
      add_case(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 16'd12345, 1,
               COORD_MAX, COORD_MIN, 1'b0);
      add_case(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 16'd65535, 1,
               COORD_MIN, COORD_MAX, 1'b0);
      add_case(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'd0, 1,
               COORD_MAX, COORD_MAX, 1'b1);
      add_case(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'd0, 1,
               COORD_MIN, COORD_MIN, 1'b1);
      add_case(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'd46080, 1,
               COORD_MAX, COORD_MAX, 1'b1);
      add_case(32'sh1000, 32'sh2000, 0, 0, 16'd23040, 0, 0, 0, 1'b0);
      add_case(32'sh1000, 32'sh2000, 0, 0, 16'd0, 0, 0, 0, 1'b0);
      add_case(32'sh12345, -32'sh6789, 32'sh100, -32'sh200, 16'd11520, 0, 0, 0, 1'b0);
      add_case(32'sh12345, -32'sh6789, 32'sh100, -32'sh200, 16'd11521, 0, 0, 0, 1'b0);
      add_case(-32'sh4444, 32'sh3333, 32'sh55, 32'sh66, 16'd34559, 0, 0, 0, 1'b0);
      add_case(-32'sh4444, 32'sh3333, 32'sh55, 32'sh66, 16'd34560, 0, 0, 0, 1'b0);
      add_case(-32'sh4444, 32'sh3333, 32'sh55, 32'sh66, 16'd34561, 0, 0, 0, 1'b0);
      add_case(32'sh7654321, 32'sh1234567, -32'sh10000, 32'sh20000, 16'd23039, 0, 0, 0, 1'b0);
      add_case(32'sh7654321, 32'sh1234567, -32'sh10000, 32'sh20000, 16'd23041, 0, 0, 0, 1'b0);
      add_case(32'sh00ABCDEF, -32'sh00FEDCBA, 0, 0, 16'd46079, 0, 0, 0, 1'b0);
      add_case(32'sh00ABCDEF, -32'sh00FEDCBA, 0, 0, 16'd65535, 0, 0, 0, 1'b0);
      add_case(32'sh00ABCDEF, -32'sh00FEDCBA, 0, 0, 16'd50000, 0, 0, 0, 1'b0);
      add_case(COORD_MAX, COORD_MAX, 0, 0, 16'd17280, 0, 0, 0, 1'b0);
      add_case(COORD_MAX, 0, 0, 0, 16'd11520, 0, 0, 0, 1'b0);
      add_case(COORD_MIN, COORD_MAX, -32'sd1, 32'sd1, 16'd5760, 0, 0, 0, 1'b0);
      add_case(32'shAAAAAAAA, 32'sh55555555, 32'sh55555555, 32'shAAAAAAAA, 16'd40000, 0,
               0, 0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_cases[i]) begin
         maybe_idle(1'b1);
         issue(corner_cases[i].stim, corner_cases[i].known, corner_cases[i].want);
      end

      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         // Alternate stretches with and without gaps; the tail runs at full rate.
         idling = ((k / 40) % 2 == 0) && (k < RANDOM_REQUESTS - CALM_TAIL);
         if (k == RANDOM_REQUESTS / 2) begin
            start <= 1'b0;
            while (rotations_due.size() != 0) @(posedge clock);
         end else begin
            maybe_idle(idling);
         end
         issue(random_request(), 1'b0, '0);
      end

      start <= 1'b0;
      while (rotations_due.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/rpac_pkg.sv
hw/rtl/rotate_point_about_center.sv
sim/rotate_point_about_center_tb.sv
